/* design/wpagc_pkg.sv */
// ----------------------------------------------------------------------------
// wpagc_pkg: shared types and constants of the windowed power AGC
// Field widths, step counts, register indexes, the sequencer states and the
// saturation helper used when the scaled sample is written out.
// ----------------------------------------------------------------------------
package wpagc_pkg;

  localparam int unsigned WindowLog2Def = 6;
  localparam int unsigned SampleW       = 16;
  localparam int unsigned PowerW        = 32;
  localparam int unsigned NormW         = 16;
  localparam int unsigned AmpW          = PowerW / 2;
  localparam int unsigned FracW         = 8;
  localparam int unsigned QuoW          = PowerW - FracW;
  localparam int unsigned AddrW         = 3;
  localparam int unsigned DataW         = 32;
  localparam int unsigned CntW          = 5;

  localparam int unsigned SqSteps   = SampleW;
  localparam int unsigned RootSteps = AmpW;
  localparam int unsigned DivSteps  = QuoW;

  localparam logic [NormW-1:0]     NormReset  = 16'd256;
  localparam logic [AddrW-1:2]     RegNormAmp = 1'b0;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_UPDATE,
    ST_SQRT,
    ST_DIV,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic load;
    logic step;
  } div_ctrl_t;

  function automatic logic signed [SampleW-1:0] sat_scale(input logic neg,
                                                          input logic [QuoW-1:0] q);
    logic signed [SampleW-1:0] res;
    if (neg) begin
      if (q > QuoW'(32768)) begin
        res = 16'sh8000;
      end else begin
        res = SampleW'(~q + QuoW'(1));
      end
    end else begin
      if (q > QuoW'(32767)) begin
        res = 16'sh7fff;
      end else begin
        res = q[SampleW-1:0];
      end
    end
    return res;
  endfunction

endpackage

/* design/wpagc_if.sv */
// ----------------------------------------------------------------------------
// wpagc_if: item channels of the windowed power AGC
// One channel carries the input samples, the other the normalized results.
// ----------------------------------------------------------------------------
interface wpagc_in_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [wpagc_pkg::SampleW-1:0]  sample_re;
  logic signed [wpagc_pkg::SampleW-1:0]  sample_im;

  modport source (output valid, output sample_re, output sample_im, input ready);
  modport sink   (input valid, input sample_re, input sample_im, output ready);
endinterface

interface wpagc_out_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [wpagc_pkg::SampleW-1:0]  result_re;
  logic signed [wpagc_pkg::SampleW-1:0]  result_im;
  logic                                  adjusted;
  logic                                  zero_power;

  modport source (output valid, output result_re, output result_im, output adjusted,
                  output zero_power, input ready);
  modport sink   (input valid, input result_re, input result_im, input adjusted,
                  input zero_power, output ready);
endinterface

/* design/wpagc_div.sv */
// ----------------------------------------------------------------------------
// wpagc_div: bit-serial restoring divider lane
// Shifts one numerator bit into the partial remainder per step and shifts
// one quotient bit in behind it; after NUM_W steps the quotient is complete.
// ----------------------------------------------------------------------------
module wpagc_div #(
  parameter int unsigned NUM_W = wpagc_pkg::QuoW,
  parameter int unsigned DEN_W = wpagc_pkg::AmpW
) (
  input  logic                  clk_i,
  input  wpagc_pkg::div_ctrl_t  ctrl_i,
  input  logic [NUM_W-1:0]      num_i,
  input  logic [DEN_W-1:0]      den_i,
  output logic [NUM_W-1:0]      quo_o
);

  logic [NUM_W-1:0] num_q;
  logic [DEN_W-1:0] rem_q;
  logic [DEN_W:0]   trial;
  logic             ge;

  always_comb begin
    trial = {rem_q, num_q[NUM_W-1]};
    ge    = trial >= (DEN_W+1)'(den_i);
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      num_q <= num_i;
      rem_q <= '0;
    end else if (ctrl_i.step) begin
      rem_q <= ge ? DEN_W'(trial - (DEN_W+1)'(den_i)) : trial[DEN_W-1:0];
      num_q <= {num_q[NUM_W-2:0], ge};
    end
  end

  assign quo_o = num_q;

endmodule

/* design/windowed_power_agc.sv */
// Windowed power AGC: each item is one complex sample, and each item gives
// exactly one result. The block keeps the powers of the last 2^WINDOW_LOG2
// samples in a ring memory and a running sum of them. Until the window has
// filled, samples pass through unchanged with adjusted low; after that both
// parts are scaled by norm_amplitude / sqrt(mean power), where norm_amplitude
// has 8 fractional bits, then truncated toward zero and saturated. Everything
// runs bit-serially through one sequencer: shift-add squaring (which also
// forms the gain products), the ring and sum update, a two-bits-per-step
// square root and restoring division of both parts in parallel. The square
// root and division are skipped during window fill, and the division when
// the measured amplitude is zero. A new item is accepted only once the last
// is worked off; a result held on a stalled output stalls the next item
// in its done state. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
// windowed_power_agc: top level of the sliding window power AGC
// Sequencer, bit-serial squarer and multiplier, square root, ring memory,
// APB register and output register.
// ----------------------------------------------------------------------------
module windowed_power_agc #(
  parameter int unsigned WINDOW_LOG2 = wpagc_pkg::WindowLog2Def
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel_i,
  input  logic                          penable_i,
  input  logic                          pwrite_i,
  input  logic [wpagc_pkg::AddrW-1:0]   paddr_i,
  input  logic [wpagc_pkg::DataW-1:0]   pwdata_i,
  output logic [wpagc_pkg::DataW-1:0]   prdata_o,
  output logic                          pready_o,
  wpagc_in_if.sink                      sample_i,
  wpagc_out_if.source                   result_o
);

  localparam int unsigned WinSize = 1 << WINDOW_LOG2;
  localparam int unsigned SumW    = WINDOW_LOG2 + wpagc_pkg::PowerW;
  localparam int unsigned PowerW  = wpagc_pkg::PowerW;
  localparam int unsigned SampleW = wpagc_pkg::SampleW;
  localparam int unsigned AmpW    = wpagc_pkg::AmpW;
  localparam int unsigned QuoW    = wpagc_pkg::QuoW;
  localparam int unsigned NormW   = wpagc_pkg::NormW;
  localparam int unsigned CntW    = wpagc_pkg::CntW;
  localparam int unsigned RemW    = AmpW + 1;

  wpagc_pkg::state_e     state_q, state_d;
  logic [CntW-1:0]       cnt_q, cnt_d;
  wpagc_pkg::div_ctrl_t  div_ctrl;
  logic                  in_ready, sq_step, upd, sqrt_step, sqrt_last, out_load;

  logic [NormW-1:0]      norm_q;
  logic                  cfg_hit;

  logic [PowerW-1:0]     ring_q [WinSize];
  logic [PowerW-1:0]     rd_q;
  logic [WINDOW_LOG2-1:0] ptr_q;
  logic [WINDOW_LOG2:0]  fill_q;
  logic [SumW-1:0]       sum_q, sum_d;
  logic                  full;

  logic signed [SampleW-1:0] re_q, im_q;
  logic [SampleW-1:0]    mag_re, mag_im;
  logic [SampleW-1:0]    mre_q, mim_q;
  logic [NormW-1:0]      nrm_q;
  logic [PowerW-1:0]     are_q, aim_q;
  logic [PowerW-1:0]     sq_acc_q, nre_q, nim_q;

  logic [PowerW-1:0]     sx_q;
  logic [RemW-1:0]       srem_q;
  logic [AmpW-1:0]       root_q, root_d;
  logic [RemW+1:0]       sr_trial, sr_rem;
  logic                  sr_ge;

  logic                  adj_q, zp_q;
  logic [QuoW-1:0]       quo_re, quo_im;

  logic                  out_valid_q;
  logic signed [SampleW-1:0] out_re_q, out_im_q;
  logic                  out_adj_q, out_zp_q;

  // Configuration port.
  assign cfg_hit  = paddr_i[wpagc_pkg::AddrW-1:2] == wpagc_pkg::RegNormAmp;
  assign pready_o = 1'b1;
  assign prdata_o = cfg_hit ? wpagc_pkg::DataW'(norm_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      norm_q <= wpagc_pkg::NormReset;
    end else if (psel_i && penable_i && pwrite_i && cfg_hit) begin
      norm_q <= pwdata_i[NormW-1:0];
    end
  end

  // Sequencer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= wpagc_pkg::ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    div_ctrl  = '0;
    in_ready  = 1'b0;
    sq_step   = 1'b0;
    upd       = 1'b0;
    sqrt_step = 1'b0;
    sqrt_last = 1'b0;
    out_load  = 1'b0;
    unique case (state_q)
      wpagc_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cnt_d    = '0;
        if (sample_i.valid) begin
          state_d = wpagc_pkg::ST_SQUARE;
        end
      end
      wpagc_pkg::ST_SQUARE: begin
        sq_step = 1'b1;
        cnt_d   = cnt_q + CntW'(1);
        if (cnt_q == CntW'(wpagc_pkg::SqSteps - 1)) begin
          state_d = wpagc_pkg::ST_UPDATE;
        end
      end
      wpagc_pkg::ST_UPDATE: begin
        upd     = 1'b1;
        cnt_d   = '0;
        state_d = full ? wpagc_pkg::ST_SQRT : wpagc_pkg::ST_DONE;
      end
      wpagc_pkg::ST_SQRT: begin
        sqrt_step = 1'b1;
        cnt_d     = cnt_q + CntW'(1);
        if (cnt_q == CntW'(wpagc_pkg::RootSteps - 1)) begin
          sqrt_last     = 1'b1;
          div_ctrl.load = 1'b1;
          cnt_d         = '0;
          state_d       = (root_d == '0) ? wpagc_pkg::ST_DONE : wpagc_pkg::ST_DIV;
        end
      end
      wpagc_pkg::ST_DIV: begin
        div_ctrl.step = 1'b1;
        cnt_d         = cnt_q + CntW'(1);
        if (cnt_q == CntW'(wpagc_pkg::DivSteps - 1)) begin
          state_d = wpagc_pkg::ST_DONE;
        end
      end
      wpagc_pkg::ST_DONE: begin
        if (!out_valid_q || result_o.ready) begin
          out_load = 1'b1;
          state_d  = wpagc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = wpagc_pkg::ST_IDLE;
      end
    endcase
  end

  assign sample_i.ready = in_ready;

  // Squarer and gain multiplier, one multiplier bit per cycle.
  assign mag_re = sample_i.sample_re[SampleW-1] ? SampleW'(-sample_i.sample_re)
                                                : SampleW'(sample_i.sample_re);
  assign mag_im = sample_i.sample_im[SampleW-1] ? SampleW'(-sample_i.sample_im)
                                                : SampleW'(sample_i.sample_im);

  always_ff @(posedge clk_i) begin
    if (in_ready && sample_i.valid) begin
      re_q     <= sample_i.sample_re;
      im_q     <= sample_i.sample_im;
      mre_q    <= mag_re;
      mim_q    <= mag_im;
      are_q    <= PowerW'(mag_re);
      aim_q    <= PowerW'(mag_im);
      nrm_q    <= norm_q;
      sq_acc_q <= '0;
      nre_q    <= '0;
      nim_q    <= '0;
    end else if (sq_step) begin
      sq_acc_q <= sq_acc_q + (mre_q[0] ? are_q : '0) + (mim_q[0] ? aim_q : '0);
      nre_q    <= nre_q + (nrm_q[0] ? are_q : '0);
      nim_q    <= nim_q + (nrm_q[0] ? aim_q : '0);
      mre_q    <= mre_q >> 1;
      mim_q    <= mim_q >> 1;
      nrm_q    <= nrm_q >> 1;
      are_q    <= are_q << 1;
      aim_q    <= aim_q << 1;
    end
  end

  // Power ring and running sum. Entries not yet written count as zero.
  always_ff @(posedge clk_i) begin
    if (in_ready && sample_i.valid) begin
      rd_q <= ring_q[ptr_q];
    end
    if (upd) begin
      ring_q[ptr_q] <= sq_acc_q;
    end
  end

  assign full  = fill_q[WINDOW_LOG2];
  assign sum_d = sum_q - (full ? SumW'(rd_q) : '0) + SumW'(sq_acc_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q  <= '0;
      fill_q <= '0;
      sum_q  <= '0;
    end else if (upd) begin
      ptr_q <= ptr_q + WINDOW_LOG2'(1);
      sum_q <= sum_d;
      if (!full) begin
        fill_q <= fill_q + (WINDOW_LOG2+1)'(1);
      end
    end
  end

  // Square root of the mean power, two radicand bits per cycle.
  always_comb begin
    sr_rem   = {srem_q, sx_q[PowerW-1:PowerW-2]};
    sr_trial = (RemW+2)'({root_q, 2'b01});
    sr_ge    = sr_rem >= sr_trial;
    root_d   = {root_q[AmpW-2:0], sr_ge};
  end

  always_ff @(posedge clk_i) begin
    if (upd) begin
      sx_q   <= sum_d[SumW-1:WINDOW_LOG2];
      srem_q <= '0;
      root_q <= '0;
      adj_q  <= full;
      zp_q   <= 1'b0;
    end else if (sqrt_step) begin
      sx_q   <= sx_q << 2;
      srem_q <= sr_ge ? RemW'(sr_rem - sr_trial) : sr_rem[RemW-1:0];
      root_q <= root_d;
      if (sqrt_last) begin
        zp_q <= root_d == '0;
      end
    end
  end

  // Quotients of both parts against the amplitude.
  wpagc_div #(
    .NUM_W (QuoW),
    .DEN_W (AmpW)
  ) u_div_re (
    .clk_i  (clk_i),
    .ctrl_i (div_ctrl),
    .num_i  (nre_q[PowerW-1:wpagc_pkg::FracW]),
    .den_i  (root_q),
    .quo_o  (quo_re)
  );

  wpagc_div #(
    .NUM_W (QuoW),
    .DEN_W (AmpW)
  ) u_div_im (
    .clk_i  (clk_i),
    .ctrl_i (div_ctrl),
    .num_i  (nim_q[PowerW-1:wpagc_pkg::FracW]),
    .den_i  (root_q),
    .quo_o  (quo_im)
  );

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_adj_q <= adj_q;
      out_zp_q  <= zp_q;
      if (!adj_q) begin
        out_re_q <= re_q;
        out_im_q <= im_q;
      end else if (zp_q) begin
        out_re_q <= '0;
        out_im_q <= '0;
      end else begin
        out_re_q <= wpagc_pkg::sat_scale(re_q[SampleW-1], quo_re);
        out_im_q <= wpagc_pkg::sat_scale(im_q[SampleW-1], quo_im);
      end
    end
  end

  assign result_o.valid      = out_valid_q;
  assign result_o.result_re  = out_re_q;
  assign result_o.result_im  = out_im_q;
  assign result_o.adjusted   = out_adj_q;
  assign result_o.zero_power = out_zp_q;

endmodule

/* design/wpagc_chk.sv */
// ----------------------------------------------------------------------------
// wpagc_chk: port-level checks of the windowed power AGC
// Watches the item channels of the top level and is bound to it below.
// ----------------------------------------------------------------------------
module wpagc_chk (
  input logic                                 clk_i,
  input logic                                 rst_ni,
  input logic                                 in_valid_i,
  input logic                                 in_ready_i,
  input logic                                 out_valid_i,
  input logic                                 out_ready_i,
  input logic signed [wpagc_pkg::SampleW-1:0] out_re_i,
  input logic signed [wpagc_pkg::SampleW-1:0] out_im_i,
  input logic                                 out_adj_i,
  input logic                                 out_zp_i
);

  // One item is worked on at a time, so input ready drops after an accept.
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input accepted twice in a row");

  a_zero_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_zp_i |-> out_adj_i && out_re_i == '0 && out_im_i == '0)
    else $error("zero power item with nonzero data or adjusted clear");

  a_fill_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_adj_i |-> !out_zp_i)
    else $error("zero power flagged during window fill");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result item dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_re_i) && $stable(out_im_i) &&
                                    $stable(out_adj_i) && $stable(out_zp_i))
    else $error("stalled result item changed");

endmodule

bind windowed_power_agc wpagc_chk u_wpagc_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (sample_i.valid),
  .in_ready_i  (sample_i.ready),
  .out_valid_i (result_o.valid),
  .out_ready_i (result_o.ready),
  .out_re_i    (result_o.result_re),
  .out_im_i    (result_o.result_im),
  .out_adj_i   (result_o.adjusted),
  .out_zp_i    (result_o.zero_power)
);
